// ===== rtl/core/bmtu_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table for the ball motion time update.
package bmtu_pkg;

   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_VALUE_WIDTH   = 32;
   localparam int ATAN_ENTRIES      = 24;

   // CORDIC datapath width and sine/cosine width
   localparam int CZ_W = 34;
   localparam int CS_W = 33;

   // inverse CORDIC gain, Q1.30
   localparam logic signed [CZ_W-1:0] KINV_Q30 = 34'sd652032874;

   localparam logic [15:0] DRAG_RESET = 16'd16384;

   typedef struct packed {
      logic signed [CS_W-1:0] cos_val;
      logic signed [CS_W-1:0] sin_val;
   } cs_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [CZ_W-1:0] atan_turn(input int unsigned idx);
      logic signed [CZ_W-1:0] r;
      unique case (idx)
         0:  r = 34'sh020000000;
         1:  r = 34'sh012E4051E;
         2:  r = 34'sh009FB385B;
         3:  r = 34'sh0051111D4;
         4:  r = 34'sh0028B0D43;
         5:  r = 34'sh00145D7E1;
         6:  r = 34'sh000A2F61E;
         7:  r = 34'sh000517C55;
         8:  r = 34'sh00028BE53;
         9:  r = 34'sh000145F2F;
         10: r = 34'sh0000A2F98;
         11: r = 34'sh0000517CC;
         12: r = 34'sh000028BE6;
         13: r = 34'sh0000145F3;
         14: r = 34'sh00000A2FA;
         15: r = 34'sh00000517D;
         16: r = 34'sh0000028BE;
         17: r = 34'sh00000145F;
         18: r = 34'sh000000A30;
         19: r = 34'sh000000518;
         20: r = 34'sh00000028C;
         21: r = 34'sh000000146;
         22: r = 34'sh0000000A3;
         23: r = 34'sh000000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/bmtu_cordic.sv =====
// Pipelined CORDIC rotator producing cosine and sine of the negated turn angle.
module bmtu_cordic #(
   parameter int CORDIC_STAGES = bmtu_pkg::DEF_CORDIC_STAGES
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [15:0]   turn_angle,
   output bmtu_pkg::cs_type     cs_out
);
   import bmtu_pkg::*;

   logic [15:0]            neg_ang;
   logic signed [31:0]     z_raw;
   logic                   flip0;
   logic signed [CZ_W-1:0] z0;

   // phi = -turn in 2^-32 turn; fold into +-quarter turn
   assign neg_ang = 16'd0 - turn_angle;
   assign z_raw   = {neg_ang, 16'd0};
   assign flip0   = (z_raw > 32'sd1073741824) || (z_raw < -32'sd1073741824);
   assign z0      = flip0 ? CZ_W'($signed({~z_raw[31], z_raw[30:0]})) : CZ_W'(z_raw);

   logic signed [CZ_W-1:0] x_ff [1:CORDIC_STAGES];
   logic signed [CZ_W-1:0] y_ff [1:CORDIC_STAGES];
   logic signed [CZ_W-1:0] z_ff [1:CORDIC_STAGES];
   logic                   fl_ff [1:CORDIC_STAGES];

   genvar i;
   generate
      for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
         logic signed [CZ_W-1:0] xp, yp, zp;
         logic                   fp;
         if (i == 0) begin : g_first
            assign xp = KINV_Q30;
            assign yp = '0;
            assign zp = z0;
            assign fp = flip0;
         end else begin : g_next
            assign xp = x_ff[i];
            assign yp = y_ff[i];
            assign zp = z_ff[i];
            assign fp = fl_ff[i];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               if (!zp[CZ_W-1]) begin
                  x_ff[i+1] <= xp - (yp >>> i);
                  y_ff[i+1] <= yp + (xp >>> i);
                  z_ff[i+1] <= zp - atan_turn(i);
               end else begin
                  x_ff[i+1] <= xp + (yp >>> i);
                  y_ff[i+1] <= yp - (xp >>> i);
                  z_ff[i+1] <= zp + atan_turn(i);
               end
               fl_ff[i+1] <= fp;
            end
         end
      end
   endgenerate

   cs_type cs_ff;
   cs_type cs_in;

   always_comb begin
      if (fl_ff[CORDIC_STAGES]) begin
         cs_in.cos_val = CS_W'(-x_ff[CORDIC_STAGES]);
         cs_in.sin_val = CS_W'(-y_ff[CORDIC_STAGES]);
      end else begin
         cs_in.cos_val = CS_W'(x_ff[CORDIC_STAGES]);
         cs_in.sin_val = CS_W'(y_ff[CORDIC_STAGES]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs_ff <= cs_in;
      end
   end

   assign cs_out = cs_ff;

endmodule

// ===== rtl/core/ball_motion_time_update.sv =====
// Top level of the ball motion time update: constant velocity prediction with odometry rotation.
//
// One item in, one item out, one item per cycle sustained while results are taken. Every item walks
// a fixed pipeline of CORDIC_STAGES+4 register stages: an input register, a multiply stage (velocity
// times time step and times drag), a position add and saturate stage, a displacement subtract stage,
// a delay line that waits for the CORDIC sine/cosine pipeline (CORDIC_STAGES rotations plus a
// quadrant-fix register, started from the input register), a rotation multiply stage and an output
// register. The whole pipeline moves as one when the output register is empty or being taken; a
// stalled rsp holds every stage. func 0 items skip the odometry step but take the same path. The
// drag factor (Q2.14, reset 1.0) is written through the csr channel, always ready, and is sampled
// with each item at entry. Results saturate to the signed range of VALUE_WIDTH clamped to 16..32
// bits.
module ball_motion_time_update #(
   parameter int CORDIC_STAGES = bmtu_pkg::DEF_CORDIC_STAGES,
   parameter int VALUE_WIDTH   = bmtu_pkg::DEF_VALUE_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic [19:0]        req_time_step,
   input  logic signed [31:0] req_disp_x,
   input  logic signed [31:0] req_disp_y,
   input  logic signed [15:0] req_turn_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_drag_factor
);
   import bmtu_pkg::*;

   localparam int LAT   = CORDIC_STAGES + 4;   // total register stages
   localparam int DLY   = CORDIC_STAGES - 2;   // data delay to meet the CORDIC output
   localparam int EXT_W = 72;                  // headroom for sums of products
   localparam int SAT_W = (VALUE_WIDTH < 16) ? 16 : ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);

   localparam logic signed [EXT_W-1:0] SAT_HI = (EXT_W'(1) <<< (SAT_W - 1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] RND14  = EXT_W'(1) <<< 13;
   localparam logic signed [EXT_W-1:0] RND16  = EXT_W'(1) <<< 15;
   localparam logic signed [EXT_W-1:0] RND30  = EXT_W'(1) <<< 29;

   function automatic logic signed [31:0] sat_val(input logic signed [EXT_W-1:0] v);
      logic signed [EXT_W-1:0] r;
      if (v > SAT_HI)      r = SAT_HI;
      else if (v < SAT_LO) r = SAT_LO;
      else                 r = v;
      return r[31:0];
   endfunction

   typedef struct packed {
      logic               func;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [19:0]        time_step;
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      logic [15:0]        drag;
   } s0_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      logic signed [52:0] vt_x;
      logic signed [52:0] vt_y;
      logic signed [48:0] vd_x;
      logic signed [48:0] vd_y;
   } s1_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nvx;
      logic signed [31:0] nvy;
   } pv_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      pv_type             pv;
   } s2_type;

   typedef struct packed {
      pv_type             pv;
      logic signed [64:0] xc;
      logic signed [64:0] ys;
      logic signed [64:0] xs;
      logic signed [64:0] yc;
   } rm_type;

   logic         adv;
   logic [LAT-1:0] vld_ff;
   logic [15:0]  drag_ff;
   s0_type       s0_ff;
   s1_type       s1_ff;
   s2_type       s2_ff;
   pv_type       s3_ff, s3_in;
   pv_type       dly_ff [DLY];
   rm_type       rm_ff;
   pv_type       out_ff, out_in;
   cs_type       cs;

   // whole pipe advances when the output register is free or being taken
   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         drag_ff <= DRAG_RESET;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req_valid};
         end
         if (csr_valid) begin
            drag_ff <= csr_drag_factor;
         end
      end
   end

   // input register
   logic signed [15:0] ang_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff.func      <= req_func;
         s0_ff.pos_x     <= req_pos_x;
         s0_ff.pos_y     <= req_pos_y;
         s0_ff.vel_x     <= req_vel_x;
         s0_ff.vel_y     <= req_vel_y;
         s0_ff.time_step <= req_time_step;
         s0_ff.disp_x    <= req_disp_x;
         s0_ff.disp_y    <= req_disp_y;
         s0_ff.drag      <= drag_ff;
         ang_ff          <= req_turn_angle;
      end
   end

   bmtu_cordic #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_cordic (
      .clock      (clock),
      .en         (adv),
      .turn_angle (ang_ff),
      .cs_out     (cs)
   );

   // multiply stage
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff.func   <= s0_ff.func;
         s1_ff.pos_x  <= s0_ff.pos_x;
         s1_ff.pos_y  <= s0_ff.pos_y;
         s1_ff.disp_x <= s0_ff.disp_x;
         s1_ff.disp_y <= s0_ff.disp_y;
         s1_ff.vt_x   <= s0_ff.vel_x * $signed({1'b0, s0_ff.time_step});
         s1_ff.vt_y   <= s0_ff.vel_y * $signed({1'b0, s0_ff.time_step});
         s1_ff.vd_x   <= s0_ff.vel_x * $signed({1'b0, s0_ff.drag});
         s1_ff.vd_y   <= s0_ff.vel_y * $signed({1'b0, s0_ff.drag});
      end
   end

   // position advance and velocity drag, round half up then saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff.func     <= s1_ff.func;
         s2_ff.disp_x   <= s1_ff.disp_x;
         s2_ff.disp_y   <= s1_ff.disp_y;
         s2_ff.pv.func  <= s1_ff.func;
         s2_ff.pv.nx    <= sat_val(EXT_W'(s1_ff.pos_x) + ((EXT_W'(s1_ff.vt_x) + RND16) >>> 16));
         s2_ff.pv.ny    <= sat_val(EXT_W'(s1_ff.pos_y) + ((EXT_W'(s1_ff.vt_y) + RND16) >>> 16));
         s2_ff.pv.nvx   <= sat_val((EXT_W'(s1_ff.vd_x) + RND14) >>> 14);
         s2_ff.pv.nvy   <= sat_val((EXT_W'(s1_ff.vd_y) + RND14) >>> 14);
      end
   end

   // robot displacement, odometry items only
   always_comb begin
      s3_in = s2_ff.pv;
      if (s2_ff.func) begin
         s3_in.nx = sat_val(EXT_W'(s2_ff.pv.nx) - EXT_W'(s2_ff.disp_x));
         s3_in.ny = sat_val(EXT_W'(s2_ff.pv.ny) - EXT_W'(s2_ff.disp_y));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= s3_in;
      end
   end

   // delay line to line up with the sine/cosine pair
   genvar k;
   generate
      for (k = 0; k < DLY; k++) begin : g_dly
         always_ff @(posedge clock) begin
            if (adv) begin
               if (k == 0) dly_ff[k] <= s3_ff;
               else        dly_ff[k] <= dly_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   endgenerate

   // rotation products
   always_ff @(posedge clock) begin
      if (adv) begin
         rm_ff.pv <= dly_ff[DLY-1];
         rm_ff.xc <= dly_ff[DLY-1].nx * cs.cos_val;
         rm_ff.ys <= dly_ff[DLY-1].ny * cs.sin_val;
         rm_ff.xs <= dly_ff[DLY-1].nx * cs.sin_val;
         rm_ff.yc <= dly_ff[DLY-1].ny * cs.cos_val;
      end
   end

   // rotation sums, Q1.30 rounding, then the output register
   always_comb begin
      out_in = rm_ff.pv;
      if (rm_ff.pv.func) begin
         out_in.nx = sat_val((EXT_W'(rm_ff.xc) - EXT_W'(rm_ff.ys) + RND30) >>> 30);
         out_in.ny = sat_val((EXT_W'(rm_ff.xs) + EXT_W'(rm_ff.yc) + RND30) >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_new_pos_x = out_ff.nx;
   assign rsp_new_pos_y = out_ff.ny;
   assign rsp_new_vel_x = out_ff.nvx;
   assign rsp_new_vel_y = out_ff.nvy;

   // a stall freezes every valid bit
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff == $past(vld_ff))
      else $error("valid bits moved during stall");

   // an accepted item occupies the input stage next cycle
   a_entry: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted item lost at entry");

   // a csr write lands in the drag register
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> drag_ff == $past(csr_drag_factor))
      else $error("drag factor write lost");

   // an untaken result is still shown next cycle
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_ff))
      else $error("pending result dropped");

endmodule

// ===== sim/bmtu_checker.sv =====
// Checker for the ball motion time update: predicts each item and compares the results.
`timescale 1ns / 100ps

module bmtu_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic [19:0]        req_time_step,
   input  logic signed [31:0] req_disp_x,
   input  logic signed [31:0] req_disp_y,
   input  logic signed [15:0] req_turn_angle,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_new_pos_x,
   input  logic signed [31:0] rsp_new_pos_y,
   input  logic signed [31:0] rsp_new_vel_x,
   input  logic signed [31:0] rsp_new_vel_y,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [15:0]        csr_drag_factor,
   output int                 fail_count,
   output int                 pending_count
);
   localparam int STAGES = 16;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } motion_t;

   localparam longint ATAN_TURN [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   logic [15:0] drag;
   motion_t     expected_q[$];

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // sine/cosine of a 2^-32-turn angle, Q1.30
   task automatic turn_sincos(input logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, xo;
      bit     flip;
      z = longint'($signed(ang));
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > (longint'(1) <<< 30) || z < -(longint'(1) <<< 30)) begin
         flip = 1;
         z = longint'($signed(ang - 32'h80000000));
      end
      for (int i = 0; i < STAGES; i++) begin
         xo = x;
         if (z >= 0) begin
            x -= y >>> i; y += xo >>> i; z -= ATAN_TURN[i];
         end else begin
            x += y >>> i; y -= xo >>> i; z += ATAN_TURN[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = x;
      s = y;
   endtask

   task automatic predict_motion(output motion_t m);
      longint nx, ny, c, s, rx, ry;
      logic [15:0] neg_turn;
      nx = clamp32(longint'(req_pos_x) + round_shift(longint'(req_vel_x) * req_time_step, 16));
      ny = clamp32(longint'(req_pos_y) + round_shift(longint'(req_vel_y) * req_time_step, 16));
      m.vel_x = 32'(clamp32(round_shift(longint'(req_vel_x) * drag, 14)));
      m.vel_y = 32'(clamp32(round_shift(longint'(req_vel_y) * drag, 14)));
      if (req_func) begin
         nx = clamp32(nx - req_disp_x);
         ny = clamp32(ny - req_disp_y);
         neg_turn = 16'd0 - req_turn_angle;
         turn_sincos({neg_turn, 16'd0}, c, s);
         rx = round_shift(nx * c - ny * s, 30);
         ry = round_shift(nx * s + ny * c, 30);
         nx = clamp32(rx);
         ny = clamp32(ry);
      end
      m.pos_x = 32'(nx);
      m.pos_y = 32'(ny);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
      $display("checker: %s mismatch got %h expected %h", what, got, exp_v);
      fail_count++;
   endtask

   assign pending_count = expected_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      motion_t m, e;
      if (reset) begin
         drag <= 16'd16384;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) drag <= csr_drag_factor;
         if (req_valid && req_ready) begin
            predict_motion(m);
            expected_q.push_back(m);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_new_pos_x !== e.pos_x) report_mismatch("pos_x", rsp_new_pos_x, e.pos_x);
               if (rsp_new_pos_y !== e.pos_y) report_mismatch("pos_y", rsp_new_pos_y, e.pos_y);
               if (rsp_new_vel_x !== e.vel_x) report_mismatch("vel_x", rsp_new_vel_x, e.vel_x);
               if (rsp_new_vel_y !== e.vel_y) report_mismatch("vel_y", rsp_new_vel_y, e.vel_y);
            end
         end
      end
   end
endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives items and drag settings into the time update and gives the verdict.
`timescale 1ns / 100ps

module tb_top;
   localparam int LATENCY   = 20;
   localparam int WDOG_MAX  = 2000;
   localparam int N_RANDOM  = 650;

   logic clock = 0;
   logic reset = 1;

   logic               req_valid = 0, req_ready;
   logic               req_func = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_vel_x = 0, req_vel_y = 0;
   logic [19:0]        req_time_step = 0;
   logic signed [31:0] req_disp_x = 0, req_disp_y = 0;
   logic signed [15:0] req_turn_angle = 0;
   logic               rsp_valid, rsp_ready = 0;
   logic signed [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_vel_x, rsp_new_vel_y;
   logic               csr_valid = 0, csr_ready;
   logic [15:0]        csr_drag_factor = 0;

   int  fail_count, pending_count;
   bit  quiet_tail = 0;     // no idling near the end
   int  idle_cycles = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   ball_motion_time_update uut (.*);

   bmtu_checker chk (.*);

   // watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // result side: random stall bursts, off in the tail
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_ready <= 1;
         n = $urandom_range(1, 12);
         repeat (n) @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
      end
   end

   // one item, held until accepted
   task automatic send_item(input logic f, input logic [31:0] px, py, vx, vy,
                            input logic [19:0] ts, input logic [31:0] dx, dy,
                            input logic [15:0] ta);
      req_valid <= 1;
      req_func <= f;
      req_pos_x <= px; req_pos_y <= py; req_vel_x <= vx; req_vel_y <= vy;
      req_time_step <= ts;
      req_disp_x <= dx; req_disp_y <= dy;
      req_turn_angle <= ta;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_drag(input logic [15:0] v);
      csr_valid <= 1;
      csr_drag_factor <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // random 32-bit value leaning on extremes and small magnitudes
   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_item;
      logic [19:0] ts;
      ts = ($urandom_range(0, 7) == 0) ? 20'hFFFFF : 20'($urandom);
      send_item(1'($urandom), pick32(), pick32(), pick32(), pick32(), ts,
                pick32(), pick32(), 16'($urandom));
   endtask

   initial begin
      logic [15:0] drag_set [5] = '{16'd0, 16'hFFFF, 16'd16384, 16'd8192, 16'd12000};
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: default drag, field extremes, both functions, all quadrant angles
      send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                20'hFFFFF, 0, 0, 0);
      send_item(0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                20'hFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'h8000);
      send_item(1, 32'h00010000, 32'h00020000, 32'h00008000, 32'hFFFF8000,
                20'h08000, 32'h00001000, 32'hFFFFF000, 16'h0000);
      send_item(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 32'h80000000, 32'h80000000,
                16'h4000);
      send_item(1, 32'h80000000, 32'h80000000, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                16'hC000);
      send_item(1, 32'h00050000, 32'hFFFB0000, 32'h00010000, 32'h00010000, 20'h10000,
                0, 0, 16'h8000);
      send_item(1, 32'h00050000, 32'h00030000, 0, 0, 0, 0, 0, 16'h7FFF);
      send_item(1, 32'h00050000, 32'h00030000, 0, 0, 0, 0, 0, 16'h8001);
      send_item(1, 32'h00050000, 32'h00030000, 0, 0, 0, 0, 0, 16'h4001);
      send_item(1, 32'h00050000, 32'h00030000, 0, 0, 0, 0, 0, 16'hBFFF);
      send_item(1, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 32'h00000001, 20'd1,
                32'hFFFFFFFF, 32'h00000001, 16'h0001);
      // sender holds off until every result is back
      drain();

      // random phases across drag settings, extremes included
      for (int p = 0; p < 5; p++) begin
         write_drag(drag_set[p]);
         for (int i = 0; i < N_RANDOM / 5; i++) begin
            if (p == 4 && i > N_RANDOM / 5 - 60) quiet_tail = 1;
            random_item();
         end
         drain();
      end

      if (fail_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule
